>>> design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the point generator RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SPG_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SPG_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SPG_ASSERT(label, clk, rst_n, prop, msg)
`define SPG_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

>>> design/spg_pkg.sv
// ----------------------------------------------------------------------------
// Spirograph point generator package
// Request types, register codes and fixed-point constants.
// ----------------------------------------------------------------------------
package spg_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OUTER_RADIUS      = 3'd0,
        CFG_ROLLING_RADIUS    = 3'd1,
        CFG_PEN_RADIUS        = 3'd2,
        CFG_SPEED_RATIO       = 3'd3,
        CFG_OUTPUT_SCALE      = 3'd4,
        CFG_REVERSE_DIRECTION = 3'd5
    } t_cfg_index;

    localparam logic [11:0] RST_OUTER_RADIUS   = 12'd1000;
    localparam logic [11:0] RST_ROLLING_RADIUS = 12'd300;
    localparam logic [11:0] RST_PEN_RADIUS     = 12'd100;
    localparam logic [11:0] RST_SPEED_RATIO    = 12'd256;
    localparam logic [15:0] RST_OUTPUT_SCALE   = 16'd4096;

    typedef struct packed {
        logic               command;
        logic signed [23:0] phase;
        logic [15:0]        phase_offset;
        logic signed [23:0] earlier_phase;
        logic [15:0]        earlier_offset;
    } t_in_req;

    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
    } t_out_req;

    localparam int NUM_W    = 36;
    localparam int DIV_W    = 24;
    localparam int QUO_W    = 32;
    localparam int DIV_BITS = NUM_W + 24;
    localparam int DIV_STEPS_PER_STAGE = 2;
    localparam int DIV_STAGES = DIV_BITS / DIV_STEPS_PER_STAGE;
    localparam int SIN_LAT  = 5;
    localparam int COMB_LAT = 4;
    localparam int LANE_LAT = 2 + DIV_STAGES + 1 + SIN_LAT + COMB_LAT;
    localparam int PNT_W    = 25;

    typedef struct packed {
        logic [11:0]        outer;
        logic [11:0]        pen;
        logic [15:0]        scale;
        logic [DIV_W-1:0]   div;
        logic signed [12:0] big;
        logic               rev;
    } t_lane_cfg;

    localparam logic [30:0] POLY_A = 31'd1686629713;
    localparam logic [30:0] POLY_B = 31'd688904866;
    localparam logic [30:0] POLY_C = 31'd76016977;
    localparam logic [30:0] Q30_ONE = 31'h4000_0000;
    localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;

endpackage

>>> design/spirograph_point_generator_unit.sv
// ----------------------------------------------------------------------------
// Spirograph point generator
// Hypotrochoid position or velocity points from phases in turns.
// ----------------------------------------------------------------------------
//  Port group      Direction  Handshake            Payload
//  request in      input      i_valid / o_stall    i_data  (t_in_req)
//  request out     output     o_valid / i_stall    o_data  (t_out_req)
//  configuration   input      i_cfg_we             i_cfg_index, i_cfg_data
//
// One request is taken every cycle while o_stall is low.
// The divider works two steps per stage.
// The latency is set by the 60-step pipelined divider and the sine units.
// Reset is synchronous and clears the valid bits and loads the registers.
// A stalled output holds the whole pipeline in place.
`include "assert_macros.svh"

module spirograph_point_generator_unit #(
    parameter int ANGLE_BITS = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  spg_pkg::t_in_req                 i_data,
    output logic                             o_valid,
    input  logic                             i_stall,
    output spg_pkg::t_out_req                o_data,
    input  logic                             i_cfg_we,
    input  logic [spg_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [spg_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int LAT = spg_pkg::LANE_LAT;
    localparam int PW  = spg_pkg::PNT_W;

    logic [11:0] r_outer, r_rolling, r_pen, r_ratio;
    logic [15:0] r_scale;
    logic        r_rev;
    logic [spg_pkg::DIV_W-1:0] r_div;
    logic signed [12:0]        r_big;

    logic [11:0] w_r_eff, w_sr_eff;
    logic        w_adv;
    spg_pkg::t_lane_cfg w_lane_cfg;

    logic r_vld [LAT];
    logic r_cmd [LAT];
    logic r_out_valid;
    spg_pkg::t_out_req r_out;

    logic signed [PW-1:0] w_x0, w_y0, w_x1, w_y1;
    logic signed [PW:0]   w_dx, w_dy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_outer   <= spg_pkg::RST_OUTER_RADIUS;
            r_rolling <= spg_pkg::RST_ROLLING_RADIUS;
            r_pen     <= spg_pkg::RST_PEN_RADIUS;
            r_ratio   <= spg_pkg::RST_SPEED_RATIO;
            r_scale   <= spg_pkg::RST_OUTPUT_SCALE;
            r_rev     <= 1'b0;
        end else if (i_cfg_we) begin
            case (spg_pkg::t_cfg_index'(i_cfg_index))
                spg_pkg::CFG_OUTER_RADIUS:      r_outer   <= i_cfg_data[11:0];
                spg_pkg::CFG_ROLLING_RADIUS:    r_rolling <= i_cfg_data[11:0];
                spg_pkg::CFG_PEN_RADIUS:        r_pen     <= i_cfg_data[11:0];
                spg_pkg::CFG_SPEED_RATIO:       r_ratio   <= i_cfg_data[11:0];
                spg_pkg::CFG_OUTPUT_SCALE:      r_scale   <= i_cfg_data;
                spg_pkg::CFG_REVERSE_DIRECTION: r_rev     <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    assign w_r_eff  = (r_rolling == '0) ? 12'd1 : r_rolling;
    assign w_sr_eff = (r_ratio == '0) ? 12'd1 : r_ratio;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div <= spg_pkg::DIV_W'(spg_pkg::RST_ROLLING_RADIUS * spg_pkg::RST_SPEED_RATIO);
            r_big <= 13'sd700;
        end else begin
            r_div <= {12'b0, w_r_eff} * {12'b0, w_sr_eff};
            r_big <= $signed({1'b0, r_outer}) - $signed({1'b0, w_r_eff});
        end
    end

    assign w_lane_cfg.outer = r_outer;
    assign w_lane_cfg.pen   = r_pen;
    assign w_lane_cfg.scale = r_scale;
    assign w_lane_cfg.div   = r_div;
    assign w_lane_cfg.big   = r_big;
    assign w_lane_cfg.rev   = r_rev;

    assign w_adv   = !r_out_valid || !i_stall;
    assign o_stall = !w_adv;

    spg_lane #(
        .ANGLE_BITS (ANGLE_BITS)
    ) u_lane_now (
        .i_clk    (i_clk),
        .i_en     (w_adv),
        .i_cfg    (w_lane_cfg),
        .i_phase  (i_data.phase),
        .i_offset (i_data.phase_offset),
        .o_x      (w_x0),
        .o_y      (w_y0)
    );

    spg_lane #(
        .ANGLE_BITS (ANGLE_BITS)
    ) u_lane_earlier (
        .i_clk    (i_clk),
        .i_en     (w_adv),
        .i_cfg    (w_lane_cfg),
        .i_phase  (i_data.earlier_phase),
        .i_offset (i_data.earlier_offset),
        .o_x      (w_x1),
        .o_y      (w_y1)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LAT; i++) begin
                r_vld[i] <= 1'b0;
            end
        end else if (w_adv) begin
            r_vld[0] <= i_valid;
            for (int i = 1; i < LAT; i++) begin
                r_vld[i] <= r_vld[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_cmd[0] <= i_data.command;
            for (int i = 1; i < LAT; i++) begin
                r_cmd[i] <= r_cmd[i-1];
            end
        end
    end

    // Both points stay far inside 32 bits, so the output needs no clamp.
    assign w_dx = r_cmd[LAT-1] ? ((PW+1)'(w_x0) - (PW+1)'(w_x1)) : (PW+1)'(w_x0);
    assign w_dy = r_cmd[LAT-1] ? ((PW+1)'(w_y0) - (PW+1)'(w_y1)) : (PW+1)'(w_y0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_vld[LAT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out.point_x <= 32'(w_dx);
            r_out.point_y <= 32'(w_dy);
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    `SPG_ASSERT(a_stall_only_when_full, i_clk, i_rst_n, o_stall |-> (o_valid && i_stall), "stall without a blocked result")
    `SPG_ASSERT(a_last_stage_reaches_out, i_clk, i_rst_n, (r_vld[LAT-1] && !o_stall) |=> o_valid, "finished request lost")
    `SPG_ASSERT(a_first_stage_holds, i_clk, i_rst_n, o_stall |=> (r_vld[0] == $past(r_vld[0])), "pipeline moved while stalled")
    `SPG_ASSERT(a_divisor_nonzero, i_clk, i_rst_n, r_div != '0, "divisor is zero")

endmodule

>>> design/spg_sine.sv
// ----------------------------------------------------------------------------
// Sine unit
// Five-stage quarter-wave polynomial sine of an angle in turns.
// ----------------------------------------------------------------------------
module spg_sine #(
    parameter int ANGLE_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic [31:0]        i_angle,
    output logic signed [31:0] o_sin
);

    localparam int LOW_BITS = 32 - ANGLE_BITS;

    logic [29:0] w_frac;
    logic [30:0] w_arg;
    logic [61:0] w_sq;
    logic [61:0] w_pc;
    logic [61:0] w_pt;
    logic [61:0] w_ps;
    logic [30:0] w_s;

    logic [30:0] r_x_s1, r_x_s2, r_x_s3, r_x_s4;
    logic        r_neg_s1, r_neg_s2, r_neg_s3, r_neg_s4;
    logic [30:0] r_x2, r_x2_s3, r_t1, r_t2;
    logic signed [31:0] r_sin;

    assign w_frac = {i_angle[29:LOW_BITS], {LOW_BITS{1'b0}}};
    assign w_arg  = i_angle[30] ? (spg_pkg::Q30_ONE - {1'b0, w_frac}) : {1'b0, w_frac};
    assign w_sq   = {31'b0, r_x_s1} * {31'b0, r_x_s1};
    assign w_pc   = {31'b0, r_x2} * {31'b0, spg_pkg::POLY_C};
    assign w_pt   = {31'b0, r_x2_s3} * {31'b0, r_t1};
    assign w_ps   = {31'b0, r_x_s4} * {31'b0, r_t2};
    assign w_s    = w_ps[60:30];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x_s1   <= w_arg;
            r_neg_s1 <= i_angle[31];
            r_x2     <= w_sq[60:30];
            r_x_s2   <= r_x_s1;
            r_neg_s2 <= r_neg_s1;
            r_t1     <= spg_pkg::POLY_B - w_pc[60:30];
            r_x2_s3  <= r_x2;
            r_x_s3   <= r_x_s2;
            r_neg_s3 <= r_neg_s2;
            r_t2     <= spg_pkg::POLY_A - w_pt[60:30];
            r_x_s4   <= r_x_s3;
            r_neg_s4 <= r_neg_s3;
            r_sin    <= r_neg_s4 ? -$signed({1'b0, w_s}) : $signed({1'b0, w_s});
        end
    end

    assign o_sin = r_sin;

endmodule

>>> design/spg_div.sv
// ----------------------------------------------------------------------------
// Pipelined divider
// Restoring long division, a fixed number of quotient bits per stage.
// ----------------------------------------------------------------------------
module spg_div #(
    parameter int SIDE_W = 33
) (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic [spg_pkg::NUM_W-1:0]    i_num,
    input  logic [spg_pkg::DIV_W-1:0]    i_div,
    input  logic [SIDE_W-1:0]            i_side,
    output logic [spg_pkg::QUO_W-1:0]    o_quo,
    output logic [SIDE_W-1:0]            o_side
);

    localparam int NW = spg_pkg::NUM_W;
    localparam int DW = spg_pkg::DIV_W;
    localparam int QW = spg_pkg::QUO_W;
    localparam int NS = spg_pkg::DIV_STAGES;

    logic [NW-1:0]     r_num  [NS];
    logic [DW-1:0]     r_rem  [NS];
    logic [QW-1:0]     r_quo  [NS];
    logic [SIDE_W-1:0] r_side [NS];

    for (genvar s = 0; s < NS; s++) begin : g_stage
        logic [NW-1:0]     w_num_in;
        logic [DW-1:0]     w_rem_in;
        logic [QW-1:0]     w_quo_in;
        logic [SIDE_W-1:0] w_side_in;
        logic [NW-1:0]     n_num;
        logic [DW-1:0]     n_rem;
        logic [QW-1:0]     n_quo;

        if (s == 0) begin : g_first
            assign w_num_in  = i_num;
            assign w_rem_in  = '0;
            assign w_quo_in  = '0;
            assign w_side_in = i_side;
        end else begin : g_next
            assign w_num_in  = r_num[s-1];
            assign w_rem_in  = r_rem[s-1];
            assign w_quo_in  = r_quo[s-1];
            assign w_side_in = r_side[s-1];
        end

        always_comb begin
            logic [DW:0] v_ext;
            n_num = w_num_in;
            n_rem = w_rem_in;
            n_quo = w_quo_in;
            v_ext = '0;
            for (int k = 0; k < spg_pkg::DIV_STEPS_PER_STAGE; k++) begin
                v_ext = {n_rem, n_num[NW-1]};
                n_num = {n_num[NW-2:0], 1'b0};
                if (v_ext >= {1'b0, i_div}) begin
                    n_rem = DW'(v_ext - {1'b0, i_div});
                    n_quo = {n_quo[QW-2:0], 1'b1};
                end else begin
                    n_rem = v_ext[DW-1:0];
                    n_quo = {n_quo[QW-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_num[s]  <= n_num;
                r_rem[s]  <= n_rem;
                r_quo[s]  <= n_quo;
                r_side[s] <= w_side_in;
            end
        end
    end

    assign o_quo  = r_quo[NS-1];
    assign o_side = r_side[NS-1];

endmodule

>>> design/spg_lane.sv
// ----------------------------------------------------------------------------
// Point lane
// Computes the scaled hypotrochoid point for one phase and offset.
// ----------------------------------------------------------------------------
module spg_lane #(
    parameter int ANGLE_BITS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_en,
    input  spg_pkg::t_lane_cfg              i_cfg,
    input  logic signed [23:0]              i_phase,
    input  logic [15:0]                     i_offset,
    output logic signed [spg_pkg::PNT_W-1:0] o_x,
    output logic signed [spg_pkg::PNT_W-1:0] o_y
);

    localparam int SIDE_W = 33;
    localparam logic signed [62:0] ROUND_HALF = 63'sh20_0000_0000;

    logic signed [24:0] w_p;
    logic [23:0]        w_mag;
    logic               w_pos;

    logic [23:0] r_mag;
    logic        r_pos_1, r_pos_2;
    logic [15:0] r_a1h_1, r_a1h_2;
    logic [15:0] r_off_1, r_off_2;
    logic [spg_pkg::NUM_W-1:0] r_num;

    logic [spg_pkg::QUO_W-1:0] w_quo;
    logic [SIDE_W-1:0]         w_side;
    logic [31:0]               w_inner;
    logic [31:0]               w_a1;
    logic [31:0]               w_a2;

    logic [31:0]        r_ang [4];
    logic signed [31:0] w_sin [4];

    logic signed [12:0] w_pen;
    logic signed [44:0] r_mx1, r_mx2, r_my1, r_my2;
    logic signed [45:0] r_sx, r_sy;
    logic signed [62:0] r_vx, r_vy;
    logic signed [62:0] w_rx, w_ry;
    logic signed [spg_pkg::PNT_W-1:0] r_px, r_py;

    assign w_p   = i_cfg.rev ? -25'(i_phase) : 25'(i_phase);
    assign w_mag = w_p[24] ? 24'(-w_p) : w_p[23:0];
    assign w_pos = !w_p[24] && (w_p != '0);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mag   <= w_mag;
            r_pos_1 <= w_pos;
            r_a1h_1 <= w_p[15:0] + i_offset;
            r_off_1 <= i_offset;
            r_num   <= {12'b0, r_mag} * {24'b0, i_cfg.outer};
            r_pos_2 <= r_pos_1;
            r_a1h_2 <= r_a1h_1;
            r_off_2 <= r_off_1;
        end
    end

    spg_div #(
        .SIDE_W (SIDE_W)
    ) u_div (
        .i_clk  (i_clk),
        .i_en   (i_en),
        .i_num  (r_num),
        .i_div  (i_cfg.div),
        .i_side ({r_pos_2, r_a1h_2, r_off_2}),
        .o_quo  (w_quo),
        .o_side (w_side)
    );

    assign w_inner = w_side[32] ? (32'd0 - w_quo) : w_quo;
    assign w_a1    = {w_side[31:16], 16'b0};
    assign w_a2    = w_inner + {w_side[15:0], 16'b0};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ang[0] <= w_a1;
            r_ang[1] <= w_a1 + spg_pkg::QUARTER_TURN;
            r_ang[2] <= w_a2;
            r_ang[3] <= w_a2 + spg_pkg::QUARTER_TURN;
        end
    end

    for (genvar g = 0; g < 4; g++) begin : g_sine
        spg_sine #(
            .ANGLE_BITS (ANGLE_BITS)
        ) u_sine (
            .i_clk   (i_clk),
            .i_en    (i_en),
            .i_angle (r_ang[g]),
            .o_sin   (w_sin[g])
        );
    end

    assign w_pen = $signed({1'b0, i_cfg.pen});
    assign w_rx  = r_vx + ROUND_HALF;
    assign w_ry  = r_vy + ROUND_HALF;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mx1 <= 45'(i_cfg.big) * 45'(w_sin[0]);
            r_mx2 <= 45'(w_pen) * 45'(w_sin[2]);
            r_my1 <= 45'(i_cfg.big) * 45'(w_sin[1]);
            r_my2 <= 45'(w_pen) * 45'(w_sin[3]);
            r_sx  <= 46'(r_mx1) + 46'(r_mx2);
            r_sy  <= 46'(r_my1) + 46'(r_my2);
            r_vx  <= 63'(r_sx) * 63'($signed({1'b0, i_cfg.scale}));
            r_vy  <= 63'(r_sy) * 63'($signed({1'b0, i_cfg.scale}));
            r_px  <= w_rx[62:38];
            r_py  <= w_ry[62:38];
        end
    end

    assign o_x = r_px;
    assign o_y = r_py;

endmodule

>>> dv/tb.sv
// ----------------------------------------------------------------------------
// Spirograph point generator testbench
// Drives position and velocity requests through the point generator under
// several register settings. Each accepted request is predicted in fixed
// point and checked field by field, with random gaps and output stalls.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ANGLE_BITS = 16;
    localparam int RUN_LIMIT  = 400000;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_stall;
    spg_pkg::t_in_req  i_data;
    logic              o_valid;
    logic              i_stall;
    spg_pkg::t_out_req o_data;
    logic              i_cfg_we;
    logic [spg_pkg::CFG_IDX_W-1:0]  i_cfg_index;
    logic [spg_pkg::CFG_DATA_W-1:0] i_cfg_data;

    spirograph_point_generator_unit #(.ANGLE_BITS(ANGLE_BITS)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall), .i_data(i_data),
        .o_valid(o_valid), .i_stall(i_stall), .o_data(o_data),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    logic [63:0] outer_r, rolling_r, pen_r, ratio_r, scale_r;
    bit          reverse_r;

    spg_pkg::t_out_req expected_points[$];
    int  errors = 0;
    int  requests_sent = 0;
    int  points_checked = 0;
    int  velocity_sent = 0;
    int  settings_used = 0;
    int  cycle_count = 0;
    int  stall_left = 0;
    bit  quiet = 0;

    initial begin
        i_clk = 0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= RUN_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic longint quarter_wave(longint x);
        longint ka, kb, kc, x2, t;
        ka = spg_pkg::POLY_A;
        kb = spg_pkg::POLY_B;
        kc = spg_pkg::POLY_C;
        x2 = (x * x) >>> 30;
        t  = kb - ((x2 * kc) >>> 30);
        t  = ka - ((x2 * t) >>> 30);
        return (x * t) >>> 30;
    endfunction

    function automatic longint turn_sine(logic [31:0] ang);
        logic [63:0] t, xu;
        logic [1:0]  quad;
        longint      s;
        t    = {32'b0, ang} >> (32 - ANGLE_BITS);
        quad = t[ANGLE_BITS-1 -: 2];
        xu   = (t << (32 - ANGLE_BITS)) & 64'h3FFF_FFFF;
        if (quad[0]) s = quarter_wave(longint'(spg_pkg::Q30_ONE) - longint'(xu));
        else s = quarter_wave(longint'(xu));
        return quad[1] ? -s : s;
    endfunction

    function automatic void trochoid_point(longint ph, logic [15:0] off,
                                           output longint px, output longint py);
        longint      p, big, pen, sx, sy;
        logic [63:0] r, sr, off32, mag, q, inner, ux, uy;
        logic [31:0] a1, a2;
        p     = reverse_r ? -ph : ph;
        r     = (rolling_r != 0) ? rolling_r : 64'd1;
        sr    = (ratio_r != 0) ? ratio_r : 64'd1;
        off32 = {32'b0, off, 16'b0};
        mag   = (p < 0) ? 64'(-p) : 64'(p);
        q     = ((mag * outer_r) << 24) / (r * sr);
        inner = (p > 0) ? (64'd0 - q) : q;
        a1    = 32'((64'(p) << 16) + off32);
        a2    = 32'(inner + off32);
        big   = longint'(outer_r) - longint'(r);
        pen   = longint'(pen_r);
        sx    = big * turn_sine(a1) + pen * turn_sine(a2);
        sy    = big * turn_sine(a1 + spg_pkg::QUARTER_TURN)
              + pen * turn_sine(a2 + spg_pkg::QUARTER_TURN);
        ux    = 64'(sx * longint'(scale_r)) + (64'd1 << 61);
        uy    = 64'(sy * longint'(scale_r)) + (64'd1 << 61);
        px    = longint'((ux + (64'd1 << 37)) >> 38) - (64'sd1 <<< 23);
        py    = longint'((uy + (64'd1 << 37)) >> 38) - (64'sd1 <<< 23);
    endfunction

    function automatic logic signed [31:0] clamp32(longint v);
        if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
        if (v < -64'sd2147483648) return 32'sh8000_0000;
        return v[31:0];
    endfunction

    function automatic spg_pkg::t_out_req predict_point(spg_pkg::t_in_req rq);
        longint            x0, y0, x1, y1;
        spg_pkg::t_out_req res;
        trochoid_point(longint'(rq.phase), rq.phase_offset, x0, y0);
        if (rq.command) begin
            trochoid_point(longint'(rq.earlier_phase), rq.earlier_offset, x1, y1);
            x0 = x0 - x1;
            y0 = y0 - y1;
        end
        res.point_x = clamp32(x0);
        res.point_y = clamp32(y0);
        return res;
    endfunction

    always @(posedge i_clk) begin
        spg_pkg::t_out_req want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            stall_left = 0;
        end else begin
            if (o_valid && !i_stall) begin
                if (expected_points.size() == 0) begin
                    $error("unexpected point x=%0d y=%0d", o_data.point_x, o_data.point_y);
                    errors++;
                end else begin
                    want = expected_points.pop_front();
                    points_checked++;
                    if (o_data.point_x !== want.point_x) begin
                        $error("point_x expected %0d actual %0d", want.point_x, o_data.point_x);
                        errors++;
                    end
                    if (o_data.point_y !== want.point_y) begin
                        $error("point_y expected %0d actual %0d", want.point_y, o_data.point_y);
                        errors++;
                    end
                end
                stall_left = quiet ? 0 : $urandom_range(14);
            end
            if (stall_left > 0) begin
                i_stall <= 1'b1;
                stall_left--;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    task automatic send_request(spg_pkg::t_in_req rq);
        int gap;
        gap = quiet ? 0 : $urandom_range(14);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= rq;
        do @(posedge i_clk); while (o_stall);
        expected_points.push_back(predict_point(rq));
        requests_sent++;
        if (rq.command) velocity_sent++;
    endtask

    task automatic drain_points();
        i_valid <= 1'b0;
        while (expected_points.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(spg_pkg::t_cfg_index idx, logic [15:0] value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            spg_pkg::CFG_OUTER_RADIUS:      outer_r   = value[11:0];
            spg_pkg::CFG_ROLLING_RADIUS:    rolling_r = value[11:0];
            spg_pkg::CFG_PEN_RADIUS:        pen_r     = value[11:0];
            spg_pkg::CFG_SPEED_RATIO:       ratio_r   = value[11:0];
            spg_pkg::CFG_OUTPUT_SCALE:      scale_r   = value;
            spg_pkg::CFG_REVERSE_DIRECTION: reverse_r = value[0];
            default: ;
        endcase
    endtask

    task automatic load_setting(logic [15:0] outer, logic [15:0] rolling, logic [15:0] pen,
                                logic [15:0] ratio, logic [15:0] scale, logic [15:0] rev);
        drain_points();
        write_reg(spg_pkg::CFG_OUTER_RADIUS, outer);
        write_reg(spg_pkg::CFG_ROLLING_RADIUS, rolling);
        write_reg(spg_pkg::CFG_PEN_RADIUS, pen);
        write_reg(spg_pkg::CFG_SPEED_RATIO, ratio);
        write_reg(spg_pkg::CFG_OUTPUT_SCALE, scale);
        write_reg(spg_pkg::CFG_REVERSE_DIRECTION, rev);
        settings_used++;
    endtask

    function automatic logic [23:0] pick_phase();
        case ($urandom_range(5))
            0: return 24'h80_0000 + 24'($urandom_range(3));
            1: return 24'h7F_FFFF - 24'($urandom_range(3));
            2: return 24'($urandom_range(8)) - 24'd4;
            3: return 24'($signed($urandom_range(131072)) - 65536);
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic spg_pkg::t_in_req random_request();
        spg_pkg::t_in_req rq;
        rq.command        = 1'($urandom_range(1));
        rq.phase          = pick_phase();
        rq.phase_offset   = 16'($urandom);
        rq.earlier_phase  = ($urandom_range(2) == 0) ? 24'($urandom) :
                            rq.phase - 24'($urandom_range(4096));
        rq.earlier_offset = $urandom_range(1) ? rq.phase_offset : 16'($urandom);
        return rq;
    endfunction

    task automatic run_random(int count);
        for (int k = 0; k < count; k++) begin
            if (k % 40 == 0) quiet = ($urandom_range(3) == 0);
            send_request(random_request());
        end
        quiet = 0;
    endtask

    task automatic test_directed_extremes();
        spg_pkg::t_in_req rq;
        logic [23:0] phases[8] = '{24'h80_0000, 24'h7F_FFFF, 24'h00_0000, 24'h00_0001,
                                   24'hFF_FFFF, 24'h01_0000, 24'h00_4000, 24'hFF_C000};
        for (int k = 0; k < 8; k++) begin
            rq = '0;
            rq.phase          = phases[k];
            rq.phase_offset   = k[0] ? 16'hFFFF : 16'h0000;
            rq.earlier_phase  = phases[7-k];
            rq.earlier_offset = 16'hFFFF;
            send_request(rq);
            rq.command = 1'b1;
            send_request(rq);
        end
        rq = '{1'b1, 24'h7F_FFFF, 16'hFFFF, 24'h80_0000, 16'h0000};
        send_request(rq);
        rq = '{1'b1, 24'h80_0000, 16'h0000, 24'h7F_FFFF, 16'hFFFF};
        send_request(rq);
        rq = '{1'b1, 24'h12_3456, 16'h8000, 24'h12_3456, 16'h8000};
        send_request(rq);
    endtask

    task automatic test_reset_setting();
        run_random(150);
    endtask

    task automatic test_register_extremes();
        load_setting(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        test_directed_extremes();
        run_random(130);
        load_setting(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        run_random(60);
        load_setting(16'h0FFF, 16'h0000, 16'h0FFF, 16'h0000, 16'hFFFF, 16'h0001);
        test_directed_extremes();
        run_random(130);
        load_setting(16'h0FFF, 16'h0001, 16'h0FFF, 16'h0100, 16'hFFFF, 16'h0000);
        run_random(130);
        load_setting(16'h0000, 16'h0FFF, 16'h0FFF, 16'h0FFF, 16'h1000, 16'h0001);
        run_random(100);
    endtask

    task automatic test_random_settings();
        for (int s = 0; s < 6; s++) begin
            load_setting(16'($urandom), 16'($urandom_range(4095, 1)), 16'($urandom),
                         16'($urandom_range(4095, 256)), 16'($urandom), 16'($urandom));
            run_random(100);
        end
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_data      = '0;
        i_stall     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        outer_r   = spg_pkg::RST_OUTER_RADIUS;
        rolling_r = spg_pkg::RST_ROLLING_RADIUS;
        pen_r     = spg_pkg::RST_PEN_RADIUS;
        ratio_r   = spg_pkg::RST_SPEED_RATIO;
        scale_r   = spg_pkg::RST_OUTPUT_SCALE;
        reverse_r = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_extremes();
        test_reset_setting();
        test_register_extremes();
        test_random_settings();

        drain_points();
        repeat (60) @(posedge i_clk);
        $display("Sent %0d requests (%0d velocity) over %0d register settings.",
                 requests_sent, velocity_sent, settings_used + 1);
        $display("Checked %0d points in %0d cycles.", points_checked, cycle_count);
        if (errors == 0 && expected_points.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule
